### rtl/core/urc_pkg.sv
package urc_pkg;

	// configuration register indexes
	localparam logic [2:0] CFG_TRIGGER  = 3'd0;
	localparam logic [2:0] CFG_TIMEOUT  = 3'd1;
	localparam logic [2:0] CFG_BUZZER   = 3'd2;
	localparam logic [2:0] CFG_NEAR     = 3'd3;
	localparam logic [2:0] CFG_FAR      = 3'd4;
	localparam logic [2:0] CFG_LED_HOLD = 3'd5;
	localparam logic [2:0] CFG_PAUSE    = 3'd6;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	// echo ticks per centimetre
	localparam logic [13:0] TICKS_PER_CM = 14'd58;

	// floor(w/58) as (w * ceil(2^20/58)) >> 20, exact for any 14-bit w
	localparam int          RECIP_SHIFT = 20;
	localparam logic [14:0] RECIP_58    = 15'd18079;

	// reset values
	localparam logic [7:0]  RST_TRIGGER  = 8'd10;
	localparam logic [13:0] RST_TIMEOUT  = 14'd10000;
	localparam logic [13:0] RST_BUZZ_LIM = 14'd580;
	localparam logic [13:0] RST_NEAR_LIM = 14'd1450;
	localparam logic [13:0] RST_FAR_LIM  = 14'd2030;
	localparam logic [19:0] RST_LED_HOLD = 20'd1000000;
	localparam logic [19:0] RST_PAUSE    = 20'd1000000;

	typedef enum logic [1:0] {
		EV_NONE,
		EV_DONE,
		EV_NO_ECHO,
		EV_TOO_LONG
	} event_t;

	// live settings, distance thresholds already scaled to ticks
	typedef struct packed {
		logic [7:0]  trigger_us;
		logic [13:0] timeout_us;
		logic [13:0] buzzer_lim;
		logic [13:0] near_lim;
		logic [13:0] far_lim;
		logic [19:0] led_hold_us;
		logic [19:0] pause_us;
	} cfg_t;

	// one result item
	typedef struct packed {
		logic        trig;
		logic        buzzer;
		logic        green;
		logic        yellow;
		logic        red;
		event_t      status;
		logic [13:0] pulse_width;
		logic [8:0]  distance;
	} res_t;

endpackage

### rtl/core/urc_div58.sv
module urc_div58
	import urc_pkg::*;
(
	input  logic [13:0] width,
	output logic [8:0]  distance
);

	logic [28:0] product;

	// reciprocal multiply, error term stays below one step over the full range
	assign product  = 29'(width) * 29'(RECIP_58);
	assign distance = product[28:RECIP_SHIFT];

endmodule

### rtl/core/urc_core.sv
module urc_core
	import urc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  logic echo,
	input  cfg_t cfg,
	output res_t res
);

	typedef enum logic [2:0] {
		PH_TRIG,
		PH_WAIT,
		PH_HIGH,
		PH_LED,
		PH_PAUSE
	} phase_t;

	typedef enum logic [1:0] {
		LED_NONE,
		LED_GREEN,
		LED_YELLOW,
		LED_RED
	} led_t;

	phase_t      phase_q, phase_d;
	logic [19:0] tick_q, tick_d, tick_inc;
	logic [13:0] width_q, width_d, width_inc;
	logic        buzzer_q, buzzer_d;
	led_t        led_q, led_d;
	event_t      ev;
	logic [13:0] pw;
	logic [8:0]  dist_cm;
	logic        lit;

	assign tick_inc  = tick_q + 20'd1;
	assign width_inc = width_q + 14'd1;
	assign lit       = (phase_q == PH_LED);

	always_comb begin
		phase_d  = phase_q;
		tick_d   = tick_q;
		width_d  = width_q;
		buzzer_d = buzzer_q;
		led_d    = led_q;
		ev       = EV_NONE;
		pw       = '0;
		case (phase_q)
			PH_TRIG: begin
				tick_d = tick_inc;
				if (tick_inc >= {12'd0, cfg.trigger_us}) begin
					phase_d = PH_WAIT;
					tick_d  = '0;
				end
			end
			PH_WAIT: begin
				if (echo) begin
					width_d = 14'd1;
					if (14'd1 >= cfg.timeout_us) begin
						ev      = EV_TOO_LONG;
						phase_d = PH_TRIG;
						tick_d  = '0;
					end else begin
						phase_d = PH_HIGH;
					end
				end else begin
					tick_d = tick_inc;
					if (tick_inc >= {6'd0, cfg.timeout_us}) begin
						ev      = EV_NO_ECHO;
						phase_d = PH_TRIG;
						tick_d  = '0;
					end
				end
			end
			PH_HIGH: begin
				if (echo) begin
					width_d = width_inc;
					if (width_inc >= cfg.timeout_us) begin
						ev      = EV_TOO_LONG;
						phase_d = PH_TRIG;
						tick_d  = '0;
					end
				end else begin
					ev       = EV_DONE;
					pw       = width_q;
					buzzer_d = (width_q <= cfg.buzzer_lim);
					if (width_q <= cfg.near_lim) begin
						led_d = LED_GREEN;
					end else if (width_q <= cfg.far_lim) begin
						led_d = LED_YELLOW;
					end else begin
						led_d = LED_RED;
					end
					tick_d = '0;
					if (cfg.led_hold_us != '0) begin
						phase_d = PH_LED;
					end else if (cfg.pause_us != '0) begin
						phase_d = PH_PAUSE;
					end else begin
						phase_d = PH_TRIG;
					end
				end
			end
			PH_LED: begin
				tick_d = tick_inc;
				if (tick_inc >= cfg.led_hold_us) begin
					tick_d  = '0;
					phase_d = (cfg.pause_us == '0) ? PH_TRIG : PH_PAUSE;
				end
			end
			PH_PAUSE: begin
				tick_d = tick_inc;
				if (tick_inc >= cfg.pause_us) begin
					phase_d = PH_TRIG;
					tick_d  = '0;
				end
			end
			default: begin
				phase_d = PH_TRIG;
				tick_d  = '0;
			end
		endcase
	end

	urc_div58 u_div (
		.width    (pw),
		.distance (dist_cm)
	);

	always_comb begin
		res.trig        = (phase_q == PH_TRIG);
		res.buzzer      = buzzer_q;
		res.green       = lit && (led_q == LED_GREEN);
		res.yellow      = lit && (led_q == LED_YELLOW);
		res.red         = lit && (led_q == LED_RED);
		res.status      = ev;
		res.pulse_width = pw;
		res.distance    = dist_cm;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_TRIG;
			tick_q   <= '0;
			width_q  <= '0;
			buzzer_q <= 1'b0;
			led_q    <= LED_NONE;
		end else if (step) begin
			phase_q  <= phase_d;
			tick_q   <= tick_d;
			width_q  <= width_d;
			buzzer_q <= buzzer_d;
			led_q    <= led_d;
		end
	end

endmodule

### rtl/core/ultrasonic_range_classifier_top.sv
// ultrasonic range classifier: each input item is one microsecond tick carrying the
// sampled echo level, and each item yields exactly one result item with the trigger
// drive, buzzer, colour leds and an event report for that tick. the sequencer fires
// the trigger, waits for the echo, measures its width, reports width and distance
// (width/58 cm), then holds the chosen led and pauses, each if set nonzero, before
// retriggering; a missing or over-long echo is reported and retriggers at once. one
// item is taken every clock unless in_stall holds it; an item waits in the input
// register and its result then waits in the output register. the loop through the
// phase/counter registers plus the reciprocal multiplier for the distance sets the
// clock limit. the user writes settings through cfg_we/cfg_idx/cfg_wdata only while
// the block is idle, a user duty; distance thresholds are scaled to ticks on write.
module ultrasonic_range_classifier_top
	import urc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration writes
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	// tick items in
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  echo_level,
	// result items out
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  trig_out,
	output logic                  buzzer_on,
	output logic                  led_green,
	output logic                  led_yellow,
	output logic                  led_red,
	output logic [1:0]            event_status,
	output logic [13:0]           pulse_width_us,
	output logic [8:0]            distance_cm
);

	cfg_t        cfg_q;
	logic [13:0] cm_ticks;

	logic        valid_s1;
	logic        echo_s1;
	logic        advance;
	logic        in_take;

	res_t        res;
	res_t        res_q;
	logic        out_valid_q;

	// centimetre setting scaled to echo ticks, 255*58 still fits 14 bits
	assign cm_ticks = 14'(14'(cfg_wdata[7:0]) * TICKS_PER_CM);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trigger_us  <= RST_TRIGGER;
			cfg_q.timeout_us  <= RST_TIMEOUT;
			cfg_q.buzzer_lim  <= RST_BUZZ_LIM;
			cfg_q.near_lim    <= RST_NEAR_LIM;
			cfg_q.far_lim     <= RST_FAR_LIM;
			cfg_q.led_hold_us <= RST_LED_HOLD;
			cfg_q.pause_us    <= RST_PAUSE;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_TRIGGER:  cfg_q.trigger_us  <= cfg_wdata[7:0];
				CFG_TIMEOUT:  cfg_q.timeout_us  <= cfg_wdata[13:0];
				CFG_BUZZER:   cfg_q.buzzer_lim  <= cm_ticks;
				CFG_NEAR:     cfg_q.near_lim    <= cm_ticks;
				CFG_FAR:      cfg_q.far_lim     <= cm_ticks;
				CFG_LED_HOLD: cfg_q.led_hold_us <= cfg_wdata;
				CFG_PAUSE:    cfg_q.pause_us    <= cfg_wdata;
				default: begin
					// writes past the register list are dropped
				end
			endcase
		end
	end

	// item moves on when the output register is empty or being drained
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			echo_s1 <= echo_level;
		end
	end

	// phase sequencer, state moves only when its item advances
	urc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.echo   (echo_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign trig_out       = res_q.trig;
	assign buzzer_on      = res_q.buzzer;
	assign led_green      = res_q.green;
	assign led_yellow     = res_q.yellow;
	assign led_red        = res_q.red;
	assign event_status   = res_q.status;
	assign pulse_width_us = res_q.pulse_width;
	assign distance_cm    = res_q.distance;

	// width and distance only carry a value on a finished measurement
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (res_q.status != EV_DONE)
			|-> (res_q.pulse_width == '0) && (res_q.distance == '0))
		else $error("width or distance set without a finished measurement");

	// distance is the exact quotient of the width by 58
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (res_q.status == EV_DONE)
			|-> (15'(res_q.distance) * 15'd58 <= 15'(res_q.pulse_width))
			&& (15'(res_q.pulse_width) < (15'(res_q.distance) + 15'd1) * 15'd58))
		else $error("distance does not match pulse width");

	// at most one led lit, and never while triggering
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> $onehot0({res_q.green, res_q.yellow, res_q.red})
			&& !(res_q.trig && (res_q.green || res_q.yellow || res_q.red)))
		else $error("led drive inconsistent");

	// a held item in the input register keeps its echo sample
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(echo_s1))
		else $error("stalled item lost in input register");

	// a blocked result stays put
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(res_q))
		else $error("stalled result changed");

endmodule
